// ===== sv/servo_bus_packet_parser_macros.svh =====
// assertion macros for the servo bus packet parser
`ifndef SERVO_BUS_PACKET_PARSER_MACROS_SVH
`define SERVO_BUS_PACKET_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define SBPP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sbpp assertion failed");
// checked on every edge, reset included
`define SBPP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("sbpp assertion failed");
`else
`define SBPP_ASSERT(lbl, prop)
`define SBPP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== sv/sbpp_pkg.sv =====
`timescale 1ns / 1ps

package sbpp_pkg;

    localparam int unsigned PARAM_DEPTH = 64;

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] LEN_OFFSET = 8'd2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_FF1  = 3'd1,
        PH_FF2  = 3'd2,
        PH_ID   = 3'd3,
        PH_LEN  = 3'd4,
        PH_CMD  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_NOT_DONE = 2'd0,
        ST_GOOD     = 2'd1,
        ST_CSUM_ERR = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] packet_id;
        logic [7:0] command_code;
        logic [7:0] param_count;
        logic       param_valid;
        logic [7:0] param_index;
        logic [7:0] param_byte;
    } result_t;

    function automatic logic [7:0] param_count_f(input logic [7:0] len);
        return (len >= LEN_OFFSET) ? 8'(len - LEN_OFFSET) : 8'd0;
    endfunction

endpackage

// ===== sv/sbpp_in_stage.sv =====
`timescale 1ns / 1ps

module sbpp_in_stage import sbpp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] rx_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign s_tready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            byte_next  = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
    end

endmodule

// ===== sv/sbpp_parser.sv =====
`timescale 1ns / 1ps
`include "servo_bus_packet_parser_macros.svh"

module sbpp_parser import sbpp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output result_t    result
);

    phase_t     phase_reg,   phase_next;
    logic [7:0] id_reg,      id_next;
    logic [7:0] len_reg,     len_next;
    logic [7:0] cmd_reg,     cmd_next;
    logic [7:0] sum_reg,     sum_next;
    logic [7:0] cnt_reg,     cnt_next;
    logic [7:0] n_params;

    assign n_params = param_count_f(len_reg);

    always_comb begin
        phase_next = phase_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        result     = '0;

        unique case (phase_reg)
            PH_FF1: begin
                phase_next = (rx_byte == SYNC_BYTE) ? PH_FF2 : PH_IDLE;
            end
            PH_FF2: begin
                if (rx_byte != SYNC_BYTE) begin
                    id_next    = rx_byte;
                    sum_next   = rx_byte;
                    phase_next = PH_ID;
                end
            end
            PH_ID: begin
                len_next   = rx_byte;
                sum_next   = 8'(sum_reg + rx_byte);
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                cmd_next   = rx_byte;
                sum_next   = 8'(sum_reg + rx_byte);
                cnt_next   = '0;
                phase_next = PH_CMD;
            end
            PH_CMD: begin
                if (cnt_reg >= n_params) begin
                    if (~sum_reg == rx_byte) begin
                        result.status = ({24'd0, cnt_reg} <= PARAM_DEPTH) ?
                                        ST_GOOD : ST_OVERFLOW;
                    end else begin
                        result.status = ST_CSUM_ERR;
                    end
                    result.packet_id    = id_reg;
                    result.command_code = cmd_reg;
                    result.param_count  = n_params;
                    phase_next          = PH_IDLE;
                end else begin
                    sum_next = 8'(sum_reg + rx_byte);
                    if ({24'd0, cnt_reg} < PARAM_DEPTH) begin
                        result.param_valid = 1'b1;
                        result.param_index = cnt_reg;
                        result.param_byte  = rx_byte;
                    end
                    cnt_next = 8'(cnt_reg + 8'd1);
                end
            end
            default: begin
                phase_next = (rx_byte == SYNC_BYTE) ? PH_FF1 : PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            id_reg    <= '0;
            len_reg   <= '0;
            cmd_reg   <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
        end
    end

    `SBPP_ASSERT(a_done_to_idle, step && result.status != ST_NOT_DONE |=> phase_reg == PH_IDLE)
    `SBPP_ASSERT(a_param_not_done, result.param_valid |-> result.status == ST_NOT_DONE)
    `SBPP_ASSERT(a_param_index_range, result.param_valid |-> {24'd0, result.param_index} < PARAM_DEPTH)
    `SBPP_ASSERT(a_quiet_fields, result.status == ST_NOT_DONE |-> result.packet_id == 8'd0 && result.command_code == 8'd0 && result.param_count == 8'd0)
    `SBPP_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> phase_reg == PH_IDLE)

endmodule

// ===== sv/sbpp_out_stage.sv =====
`timescale 1ns / 1ps

module sbpp_out_stage import sbpp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  result_t     result,
    output logic        advance,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    result_t res_next;

    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.param_byte, res_reg.param_index, res_reg.param_count,
                       res_reg.command_code, res_reg.packet_id};
    assign m_tuser  = {res_reg.param_valid, res_reg.status};

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (advance) begin
            valid_next = in_valid;
            res_next   = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

endmodule

// ===== sv/servo_bus_packet_parser.sv =====
`timescale 1ns / 1ps
// channel   dir  tdata (low bit up)                                        tuser
// s_        in   rx_byte[7:0]                                              -
// m_        out  packet_id, command_code, param_count, param_index,        status, param_valid
//                param_byte (8 bits each)
// one result per received byte, through the input register and then the result register
// one byte per cycle while m_ is ready; the parse state updates as a byte enters the result register
// synchronous active-low reset returns the parser to header hunt with empty state
// a stall on m_ holds the result register and backs up through the input register

module servo_bus_packet_parser import sbpp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // packet_id, command_code, param_count, param_index, param_byte
    output logic [2:0]  m_tuser     // status[1:0], param_valid
);

    logic       advance;
    logic       byte_valid;
    logic [7:0] rx_byte;
    result_t    result;

    sbpp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte)
    );

    sbpp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (byte_valid && advance),
        .rx_byte (rx_byte),
        .result  (result)
    );

    sbpp_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (byte_valid),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
